// ===== rtl/ukol_pkg.sv =====
package ukol_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;

    localparam logic [2:0] FN_ADD_FIRST  = 3'd0;
    localparam logic [2:0] FN_ADD_LAST   = 3'd1;
    localparam logic [2:0] FN_ADD_AFTER  = 3'd2;
    localparam logic [2:0] FN_ADD_BEFORE = 3'd3;
    localparam logic [2:0] FN_REMOVE     = 3'd4;
    localparam logic [2:0] FN_REVERSE    = 3'd5;
    localparam logic [2:0] FN_READ_OUT   = 3'd6;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] key;
        logic signed [31:0] anchor_key;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_key;
        logic [6:0]         entry_count;
        logic               last;
    } t_out;

endpackage

// ===== rtl/ukol_ram.sv =====
module ukol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/unique_key_ordered_list_core.sv =====
// Channel  Valid        Stall        Payload
// in       i_in_valid   o_in_stall   i_in_data  (ukol_pkg::t_in, one command)
// out      o_out_valid  i_out_stall  o_out_data (ukol_pkg::t_out, one result)
//
// One command at a time; o_in_stall is high until its last result is in the output register.
// A key lookup walks the held keys through the RAM read port,
// twice for add after / add before (key, then anchor).
// Insert: shift the keys from the insert point up, then write the key. Remove: shift the keys above it down.
// Read out reads each held key (S_RD), then loads it into the output register (S_RL); any other command ends in S_RES.
// Reset clears state, output valid, count and order but not the keys; the key RAM needs no clearing pass.
module unique_key_ordered_list_core #(
    parameter int CAPACITY  = ukol_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ukol_pkg::KEY_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ukol_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ukol_pkg::t_out o_out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_UP    = 8'b0000_0100,
        S_DN    = 8'b0000_1000,
        S_WRITE = 8'b0001_0000,
        S_RES   = 8'b0010_0000,
        S_RD    = 8'b0100_0000,
        S_RL    = 8'b1000_0000
    } t_state;

    t_state               r_state;
    logic [2:0]           r_func;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] r_anchor;
    logic [CW-1:0]        r_count;
    logic                 r_flip;
    logic [CW-1:0]        r_idx;
    logic                 r_rv;
    logic [AW-1:0]        r_rd_addr;
    logic                 r_pass;
    logic [CW-1:0]        r_q;
    logic [2:0]           r_status;
    logic                 r_out_vld;
    ukol_pkg::t_out       r_out;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    logic                 in_acc;
    logic                 can_load;
    logic                 full;
    logic                 hit;
    logic                 rd_last;
    logic [KEY_WIDTH-1:0] target;
    logic [CW-1:0]        a_ext;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign can_load = !r_out_vld || !i_out_stall;
    assign full     = (r_count == CW'(CAPACITY));
    assign target   = r_pass ? r_anchor : r_key;
    assign hit      = r_rv && (ram_rdata == target);
    assign rd_last  = ((r_idx + 1'b1) == r_count);
    assign a_ext    = CW'(r_rd_addr);

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        case (r_state)
            S_SCAN: begin
                ram_re    = (r_idx < r_count);
                ram_raddr = AW'(r_idx);
            end
            S_UP: begin
                ram_re    = (r_idx > r_q);
                ram_raddr = AW'(r_idx - 1'b1);
                ram_we    = r_rv;
                ram_waddr = AW'(r_rd_addr + 1'b1);
            end
            S_DN: begin
                ram_re    = (r_idx < r_count);
                ram_raddr = AW'(r_idx);
                ram_we    = r_rv;
                ram_waddr = AW'(r_rd_addr - 1'b1);
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_q);
                ram_wdata = r_key;
            end
            S_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_flip ? AW'(r_count - 1'b1 - r_idx) : AW'(r_idx);
            end
            default: begin
            end
        endcase
    end

    ukol_ram #(
        .WIDTH(KEY_WIDTH),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_flip    <= 1'b0;
            r_out_vld <= 1'b0;
            r_rv      <= 1'b0;
        end else begin
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_func   <= i_in_data.func;
                        r_key    <= KEY_WIDTH'(64'(unsigned'(i_in_data.key)));
                        r_anchor <= KEY_WIDTH'(64'(unsigned'(i_in_data.anchor_key)));
                        r_idx    <= '0;
                        r_rv     <= 1'b0;
                        r_pass   <= 1'b0;
                        case (i_in_data.func)
                            ukol_pkg::FN_ADD_FIRST, ukol_pkg::FN_ADD_LAST,
                            ukol_pkg::FN_ADD_AFTER, ukol_pkg::FN_ADD_BEFORE: begin
                                r_state <= S_SCAN;
                            end
                            ukol_pkg::FN_REMOVE: begin
                                if (r_count == '0) begin
                                    r_status <= ukol_pkg::ST_EMPTY;
                                    r_state  <= S_RES;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            ukol_pkg::FN_REVERSE: begin
                                r_flip   <= !r_flip;
                                r_status <= ukol_pkg::ST_DONE;
                                r_state  <= S_RES;
                            end
                            ukol_pkg::FN_READ_OUT: begin
                                if (r_count == '0) begin
                                    r_status <= ukol_pkg::ST_EMPTY;
                                    r_state  <= S_RES;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                r_status <= ukol_pkg::ST_DONE;
                                r_state  <= S_RES;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_rv      <= ram_re;
                    r_rd_addr <= ram_raddr;
                    if (ram_re) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (hit) begin
                        r_rv <= 1'b0;
                        if (!r_pass) begin
                            if (r_func == ukol_pkg::FN_REMOVE) begin
                                r_idx   <= a_ext + 1'b1;
                                r_state <= S_DN;
                            end else begin
                                r_status <= ukol_pkg::ST_DUPLICATE;
                                r_state  <= S_RES;
                            end
                        end else if (full) begin
                            r_status <= ukol_pkg::ST_FULL;
                            r_state  <= S_RES;
                        end else begin
                            if (r_func == ukol_pkg::FN_ADD_AFTER) begin
                                r_q <= r_flip ? a_ext : a_ext + 1'b1;
                            end else begin
                                r_q <= r_flip ? a_ext + 1'b1 : a_ext;
                            end
                            r_idx   <= r_count;
                            r_state <= S_UP;
                        end
                    end else if (!r_rv && (r_idx == r_count)) begin
                        if (r_pass || (r_func == ukol_pkg::FN_REMOVE)) begin
                            r_status <= ukol_pkg::ST_NOT_FOUND;
                            r_state  <= S_RES;
                        end else if ((r_func == ukol_pkg::FN_ADD_FIRST) ||
                                     (r_func == ukol_pkg::FN_ADD_LAST)) begin
                            if (full) begin
                                r_status <= ukol_pkg::ST_FULL;
                                r_state  <= S_RES;
                            end else begin
                                if (r_func == ukol_pkg::FN_ADD_FIRST) begin
                                    r_q <= r_flip ? r_count : '0;
                                end else begin
                                    r_q <= r_flip ? '0 : r_count;
                                end
                                r_state <= S_UP;
                            end
                        end else if (r_count == '0) begin
                            r_status <= ukol_pkg::ST_EMPTY;
                            r_state  <= S_RES;
                        end else begin
                            r_pass <= 1'b1;
                            r_idx  <= '0;
                        end
                    end
                end
                S_UP: begin
                    r_rv      <= ram_re;
                    r_rd_addr <= ram_raddr;
                    if (ram_re) begin
                        r_idx <= r_idx - 1'b1;
                    end else if (!r_rv) begin
                        r_state <= S_WRITE;
                    end
                end
                S_DN: begin
                    r_rv      <= ram_re;
                    r_rd_addr <= ram_raddr;
                    if (ram_re) begin
                        r_idx <= r_idx + 1'b1;
                    end else if (!r_rv) begin
                        r_count  <= r_count - 1'b1;
                        r_status <= ukol_pkg::ST_DONE;
                        r_state  <= S_RES;
                    end
                end
                S_WRITE: begin
                    r_count  <= r_count + 1'b1;
                    r_status <= ukol_pkg::ST_DONE;
                    r_state  <= S_RES;
                end
                S_RES: begin
                    if (can_load) begin
                        r_out_vld         <= 1'b1;
                        r_out.status      <= r_status;
                        r_out.out_key     <= '0;
                        r_out.entry_count <= 7'(r_count);
                        r_out.last        <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_RL;
                end
                S_RL: begin
                    if (can_load) begin
                        r_out_vld         <= 1'b1;
                        r_out.status      <= ukol_pkg::ST_DONE;
                        r_out.out_key     <= 32'(64'(ram_rdata));
                        r_out.entry_count <= 7'(r_count);
                        r_out.last        <= rd_last;
                        if (rd_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/ukol_chk.sv =====
module ukol_chk #(
    parameter int CAPACITY = ukol_pkg::CAPACITY_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input ukol_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while a command is in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CAPACITY > 127) || (o_out_data.entry_count <= 7'(CAPACITY)))
        else $error("entry count above capacity");

    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ukol_pkg::ST_DONE)
        |-> o_out_data.last && (o_out_data.out_key == '0))
        else $error("non-done status without last or with a key");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ukol_pkg::ST_DONE) ||
                        (o_out_data.status == ukol_pkg::ST_DUPLICATE) ||
                        (o_out_data.status == ukol_pkg::ST_NOT_FOUND) ||
                        (o_out_data.status == ukol_pkg::ST_FULL) ||
                        (o_out_data.status == ukol_pkg::ST_EMPTY))
        else $error("undefined status code");

endmodule

bind unique_key_ordered_list_core ukol_chk #(.CAPACITY(CAPACITY)) u_chk (.*);
